// ===== hw/rtl/xgcd_pkg.sv =====
`default_nettype none

package xgcd_pkg;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture operands, seed the coefficient pairs
    logic div_start;   // start a quotient/remainder pass on r0 / r1
    logic red_start;   // start the final pass that reduces s0 by the modulus
    logic div_step;    // one restoring division bit
    logic update;      // rotate remainders and coefficients
    logic out_load;    // move the finished item into the result register
  } xgcd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic r1_zero;     // current remainder is zero, loop is over
    logic mod_zero;    // captured modulus is zero
    logic div_last;    // the current division bit is the last one
  } xgcd_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xgcd_if.sv =====
`default_nettype none

interface xgcd_in_if #(
  parameter int WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink (input valid, input value, input modulus, output ready);
endinterface

interface xgcd_out_if #(
  parameter int WIDTH = 32
);
  logic               valid;
  logic               ready;
  logic [WIDTH-1:0]   divisor;
  logic signed [WIDTH:0] coeff_value;
  logic signed [WIDTH:0] coeff_modulus;
  logic [WIDTH-1:0]   inverse;
  logic               zero_modulus;

  modport source (output valid, output divisor, output coeff_value, output coeff_modulus,
                  output inverse, output zero_modulus, input ready);
  modport sink (input valid, input divisor, input coeff_value, input coeff_modulus,
                input inverse, input zero_modulus, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/xgcd_ctrl.sv =====
`default_nettype none

module xgcd_ctrl
  import xgcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output xgcd_cmd_t      cmd,
  input  wire xgcd_sts_t sts
);

  typedef enum logic [5:0] {
    IDLE   = 6'b000001,
    CHECK  = 6'b000010,
    DIV    = 6'b000100,
    UPDATE = 6'b001000,
    RED    = 6'b010000,
    FINISH = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        priority if (!sts.r1_zero) begin
          cmd.div_start = 1'b1;
          state_next    = DIV;
        end else if (sts.mod_zero) begin
          state_next = FINISH;
        end else begin
          cmd.red_start = 1'b1;
          state_next    = RED;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = UPDATE;
      end
      UPDATE: begin
        cmd.update = 1'b1;
        state_next = CHECK;
      end
      RED: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = FINISH;
      end
      FINISH: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/xgcd_dpath.sv =====
`default_nettype none

module xgcd_dpath
  import xgcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic [WIDTH-1:0] value,
  input  wire logic [WIDTH-1:0] modulus,
  input  wire xgcd_cmd_t        cmd,
  output xgcd_sts_t             sts,
  output logic [WIDTH-1:0]      divisor,
  output logic signed [WIDTH:0] coeff_value,
  output logic signed [WIDTH:0] coeff_modulus,
  output logic [WIDTH-1:0]      inverse,
  output logic                  zero_modulus
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]      r0, r1, modr;
  logic signed [WIDTH:0] s0, s1, t0, t1;
  logic [WIDTH-1:0]      rem, dq;
  logic [WIDTH:0]        acc_s, acc_t;
  logic [CW-1:0]         cnt;
  logic                  red;

  logic [WIDTH-1:0] dsor;
  logic [WIDTH:0]   rem_sh, diff, s0_neg;
  logic             ge;
  logic [WIDTH-1:0] s0_mag;

  assign dsor   = red ? modr : r1;
  assign rem_sh = {rem, dq[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dsor};
  assign ge     = (rem_sh >= {1'b0, dsor});
  assign s0_neg = -s0;
  assign s0_mag = s0[WIDTH] ? s0_neg[WIDTH-1:0] : s0[WIDTH-1:0];

  assign sts.r1_zero  = (r1 == '0);
  assign sts.mod_zero = (modr == '0);
  assign sts.div_last = (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0   <= value;
      r1   <= modulus;
      modr <= modulus;
      s0   <= (WIDTH+1)'(1);
      s1   <= '0;
      t0   <= '0;
      t1   <= (WIDTH+1)'(1);
    end
    if (cmd.div_start || cmd.red_start) begin
      dq    <= cmd.red_start ? s0_mag : r0;
      rem   <= '0;
      acc_s <= '0;
      acc_t <= '0;
      cnt   <= CW'(WIDTH);
      red   <= cmd.red_start;
    end
    if (cmd.div_step) begin
      // one quotient bit, and fold it into q*s1 and q*t1
      rem   <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      dq    <= {dq[WIDTH-2:0], 1'b0};
      acc_s <= {acc_s[WIDTH-1:0], 1'b0} + (ge ? s1 : '0);
      acc_t <= {acc_t[WIDTH-1:0], 1'b0} + (ge ? t1 : '0);
      cnt   <= cnt - CW'(1);
    end
    if (cmd.update) begin
      r0 <= r1;
      r1 <= rem;
      s0 <= s1;
      s1 <= s0 - acc_s;
      t0 <= t1;
      t1 <= t0 - acc_t;
    end
    if (cmd.out_load) begin
      divisor       <= r0;
      coeff_value   <= s0;
      coeff_modulus <= t0;
      zero_modulus  <= sts.mod_zero;
      priority if (sts.mod_zero) inverse <= '0;
      else if (s0[WIDTH] && rem != '0) inverse <= modr - rem;
      else inverse <= rem;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/extended_gcd_modular_inverse.sv =====
`default_nettype none

// Channel    Dir  Payload                                                    
// operands   in   value, modulus                                             
// result     out  divisor, coeff_value, coeff_modulus, inverse, zero_modulus 
//
// One item at a time. Each Euclid step is a test, WIDTH restoring division
// bits and a rotate; a final pass then reduces s0 by the modulus, unless the modulus is zero.
// Reset clears the controller and the result valid flag.
// A finished item waits in the result register while the next one runs;
// the controller holds in its last state if that register is still full.

module extended_gcd_modular_inverse
  import xgcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  xgcd_in_if.sink   operands,
  xgcd_out_if.source result
);

  xgcd_cmd_t cmd;
  xgcd_sts_t sts;

  xgcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  xgcd_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk           (clk),
    .value         (operands.value),
    .modulus       (operands.modulus),
    .cmd           (cmd),
    .sts           (sts),
    .divisor       (result.divisor),
    .coeff_value   (result.coeff_value),
    .coeff_modulus (result.coeff_modulus),
    .inverse       (result.inverse),
    .zero_modulus  (result.zero_modulus)
  );

`ifndef ASSERT_OFF
  a_no_div_by_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.r1_zero)
    else $error("division started with zero remainder");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !operands.ready)
    else $error("new item taken while one is in flight");

  a_zero_mod_inverse: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_modulus |-> result.inverse == '0)
    else $error("inverse not zero for zero modulus");
`endif

endmodule

`default_nettype wire
